[rtl/core/lsbg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED scanner bar graph package
// Shared widths, command and register codes, state and result types, and
// the thermometer threshold table of the LED scanner with bar graph.
// ----------------------------------------------------------------------------
package lsbg_pkg;

   localparam int NUM_LEDS    = 10;
   localparam int SAMPLE_BITS = 10;
   localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
   localparam int BAR_STEPS   = 10;

   localparam int DOT_BITS    = 4;
   localparam int TICK_BITS   = 3;
   localparam int SECOND_BITS = 8;
   localparam int THRESH_BITS = 10;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 10;
   localparam int BAR_CNT_BITS  = 5;

   localparam logic [THRESH_BITS-1:0] SPEED_THRESHOLD_RESET = 10'd614;
   localparam logic [TICK_BITS-1:0]   SLOW_DIVIDER_RESET    = 3'd4;
   localparam logic [SECOND_BITS-1:0] MODE_PERIOD_RESET     = 8'd16;
   localparam logic [TICK_BITS-1:0]   TICK_MAX              = 3'd7;

   typedef enum logic [1:0] {
      CMD_FAST_TICK   = 2'd0,
      CMD_SECOND_TICK = 2'd1,
      CMD_SAMPLE      = 2'd2,
      CMD_IDLE        = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_SPEED_THRESHOLD = 2'd0,
      REG_SLOW_DIVIDER    = 2'd1,
      REG_MODE_PERIOD     = 2'd2,
      REG_UNUSED          = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [THRESH_BITS-1:0] speed_threshold;
      logic [TICK_BITS-1:0]   slow_divider;
      logic [SECOND_BITS-1:0] mode_period;
   } cfg_type;

   typedef struct packed {
      logic [DOT_BITS-1:0]    dot_position;
      logic                   moving_down;
      logic [TICK_BITS-1:0]   tick_count;
      logic [SECOND_BITS-1:0] second_count;
      logic                   inverted_mode;
      logic [SAMPLE_BITS-1:0] latest_sample;
      logic                   sample_pending;
      logic [NUM_LEDS-1:0]    shown_pattern;
   } state_type;

   typedef struct packed {
      logic [NUM_LEDS-1:0] led_pattern;
      logic                pattern_changed;
   } result_type;

   // Bar length k applies below the k-th tenth of full scale.
   function automatic logic [SAMPLE_BITS-1:0] bar_threshold(input int unsigned k);
      bar_threshold = SAMPLE_BITS'((SAMPLE_MAX * k) / BAR_STEPS);
   endfunction

endpackage
`default_nettype wire

[rtl/core/lsbg_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event channel interface
// Valid/ready channel carrying one event: command, sample and button level.
// ----------------------------------------------------------------------------
interface lsbg_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      cmd;
   logic [lsbg_pkg::SAMPLE_BITS-1:0] sample;
   logic                            button_pressed;

   modport source (output valid, output cmd, output sample, output button_pressed,
                   input ready);
   modport sink (input valid, input cmd, input sample, input button_pressed,
                 output ready);
endinterface
`default_nettype wire

[rtl/core/lsbg_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying the LED drive word and the change flag.
// ----------------------------------------------------------------------------
interface lsbg_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lsbg_pkg::NUM_LEDS-1:0] led_pattern;
   logic                         pattern_changed;

   modport source (output valid, output led_pattern, output pattern_changed,
                   input ready);
   modport sink (input valid, input led_pattern, input pattern_changed,
                 output ready);
endinterface
`default_nettype wire

[rtl/core/lsbg_csr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Register write interface
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface lsbg_csr_if;
   logic                               valid;
   logic                               ready;
   logic [lsbg_pkg::CSR_IDX_BITS-1:0]  index;
   logic [lsbg_pkg::CSR_DATA_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/lsbg_update.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED scanner next-state logic
// Applies one event to the scanner state and forms the result beat.
// ----------------------------------------------------------------------------
module lsbg_update (
   input  wire logic [1:0]                        cmd,
   input  wire logic [lsbg_pkg::SAMPLE_BITS-1:0]  sample,
   input  wire logic                              button_pressed,
   input  wire lsbg_pkg::cfg_type                 cfg,
   input  wire lsbg_pkg::state_type               cur,
   output lsbg_pkg::state_type                    nxt,
   output lsbg_pkg::result_type                   result
);

   logic [lsbg_pkg::TICK_BITS-1:0]    tick_inc;
   logic [lsbg_pkg::SECOND_BITS-1:0]  second_inc;
   logic [15:0]                       dot_onehot;
   logic [lsbg_pkg::NUM_LEDS-1:0]     dot_bit;
   logic [lsbg_pkg::DOT_BITS-1:0]     dot_moved;
   logic                              do_step;
   logic [lsbg_pkg::SAMPLE_BITS-1:0]  bar_sample;
   logic [lsbg_pkg::BAR_CNT_BITS-1:0] bar_count;
   logic [lsbg_pkg::NUM_LEDS-1:0]     bar_pattern;
   logic                              changed;

   always_comb begin
      tick_inc   = (cur.tick_count < lsbg_pkg::TICK_MAX) ? cur.tick_count + 3'd1
                                                        : lsbg_pkg::TICK_MAX;
      second_inc = cur.second_count + 8'd1;
      dot_onehot = 16'd1 << cur.dot_position;
      dot_bit    = dot_onehot[lsbg_pkg::NUM_LEDS-1:0];
      dot_moved  = cur.moving_down ? cur.dot_position - 4'd1 : cur.dot_position + 4'd1;
      do_step    = !button_pressed &&
                   ((cur.latest_sample <= cfg.speed_threshold) ||
                    (tick_inc >= cfg.slow_divider));
      // The bar uses the sample as left by this event's own update.
      bar_sample = (cmd == lsbg_pkg::CMD_SAMPLE) ? sample : cur.latest_sample;
   end

   // Thermometer length: first tenth of full scale that the sample lies below.
   always_comb begin
      bar_count = lsbg_pkg::BAR_CNT_BITS'(lsbg_pkg::BAR_STEPS);
      for (int k = lsbg_pkg::BAR_STEPS - 1; k >= 1; k--) begin
         if (bar_sample < lsbg_pkg::bar_threshold(k)) begin
            bar_count = lsbg_pkg::BAR_CNT_BITS'(k);
         end
      end
      if (bar_count > lsbg_pkg::BAR_CNT_BITS'(lsbg_pkg::NUM_LEDS)) begin
         bar_count = lsbg_pkg::BAR_CNT_BITS'(lsbg_pkg::NUM_LEDS);
      end
      for (int i = 0; i < lsbg_pkg::NUM_LEDS; i++) begin
         bar_pattern[i] = (lsbg_pkg::BAR_CNT_BITS'(i) < bar_count);
      end
   end

   always_comb begin
      nxt     = cur;
      changed = 1'b0;
      case (cmd)
         lsbg_pkg::CMD_FAST_TICK: begin
            nxt.tick_count = tick_inc;
            if (do_step) begin
               nxt.shown_pattern = cur.inverted_mode ? ~dot_bit : dot_bit;
               nxt.dot_position  = dot_moved;
               if (dot_moved >= lsbg_pkg::DOT_BITS'(lsbg_pkg::NUM_LEDS - 1) ||
                   dot_moved == '0) begin
                  nxt.moving_down = !cur.moving_down;
               end
               nxt.tick_count = '0;
               changed        = 1'b1;
            end
         end
         lsbg_pkg::CMD_SECOND_TICK: begin
            nxt.second_count = second_inc;
            if (second_inc >= cfg.mode_period) begin
               nxt.inverted_mode = !cur.inverted_mode;
               nxt.second_count  = '0;
            end
         end
         lsbg_pkg::CMD_SAMPLE: begin
            nxt.latest_sample  = sample;
            nxt.sample_pending = 1'b1;
         end
         default: begin
         end
      endcase

      if (button_pressed && nxt.sample_pending) begin
         nxt.shown_pattern  = bar_pattern;
         nxt.sample_pending = 1'b0;
         changed            = 1'b1;
      end

      result.led_pattern     = nxt.shown_pattern;
      result.pattern_changed = changed;
   end

endmodule
`default_nettype wire

[rtl/core/led_scanner_bar_graph.sv]
// Path: an event beat once taken waits in the input register; the update then fills
// the result register once it is free or draining, and that register drives the result beat.
// Throughput: one event per cycle while results drain; the scanner state updates
// combinationally, so only a stalled result channel holds the input back.
// Reset (synchronous): registers return to 614 / 4 / 16, scanner state clears
// to dot at LED 0 moving up, normal display, all LEDs off, no sample pending.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED scanner with bar graph
// Bouncing-dot scanner with timed display inversion and a thermometer bar
// driven by converter samples while the button is held.
// ----------------------------------------------------------------------------
module led_scanner_bar_graph (
   input wire logic   clock,
   input wire logic   reset,
   lsbg_req_if.sink   req_chan,
   lsbg_rsp_if.source rsp_chan,
   lsbg_csr_if.sink   csr_chan
);

   lsbg_pkg::cfg_type    cfg_ff;
   lsbg_pkg::state_type  state_ff;
   lsbg_pkg::state_type  state_in;
   lsbg_pkg::result_type result_in;
   lsbg_pkg::result_type result_ff;

   logic                            in_valid_ff;
   logic [1:0]                      in_cmd_ff;
   logic [lsbg_pkg::SAMPLE_BITS-1:0] in_sample_ff;
   logic                            in_button_ff;
   logic                            rsp_valid_ff;
   logic                            advance;
   logic                            req_take;

   // The held event moves on whenever the result register is free or draining.
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready           = !in_valid_ff || advance;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.led_pattern     = result_ff.led_pattern;
   assign rsp_chan.pattern_changed = result_ff.pattern_changed;
   assign csr_chan.ready           = 1'b1;

   lsbg_update u_update (
      .cmd            (in_cmd_ff),
      .sample         (in_sample_ff),
      .button_pressed (in_button_ff),
      .cfg            (cfg_ff),
      .cur            (state_ff),
      .nxt            (state_in),
      .result         (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_threshold <= lsbg_pkg::SPEED_THRESHOLD_RESET;
         cfg_ff.slow_divider    <= lsbg_pkg::SLOW_DIVIDER_RESET;
         cfg_ff.mode_period     <= lsbg_pkg::MODE_PERIOD_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            lsbg_pkg::REG_SPEED_THRESHOLD: begin
               cfg_ff.speed_threshold <= csr_chan.data[lsbg_pkg::THRESH_BITS-1:0];
            end
            lsbg_pkg::REG_SLOW_DIVIDER: begin
               cfg_ff.slow_divider <= csr_chan.data[lsbg_pkg::TICK_BITS-1:0];
            end
            lsbg_pkg::REG_MODE_PERIOD: begin
               cfg_ff.mode_period <= csr_chan.data[lsbg_pkg::SECOND_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff    <= req_chan.cmd;
         in_sample_ff <= req_chan.sample;
         in_button_ff <= req_chan.button_pressed;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

endmodule
`default_nettype wire
